// ----- design/pairwise_force_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// Pairwise force accumulator assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_FORCE_ACCUMULATOR_DEFINES_SVH
`define PAIRWISE_FORCE_ACCUMULATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfa check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfa check failed");

`endif

// ----- design/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Pairwise force accumulator package
// Widths, configuration codes, shared types and back-end states.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int COORD_INT_BITS_DEF = 10;
  localparam int SUM_WIDTH_DEF      = 40;

  localparam int POS_W      = 16;
  localparam int COEF_W     = 10;
  localparam int DELTA_W    = 17;
  localparam int GRID_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FORCE_W    = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;

  localparam int DIV_N_W    = 48;
  localparam int DIV_D_W    = 32;
  localparam int DIV_CNT_W  = 6;
  localparam int ROOT_W     = 32;
  localparam int F_W        = 18;
  localparam int UNIT_W     = 18;
  localparam int UPROD_W    = 36;
  localparam int GAIN_W     = 32;
  localparam int STEP_CNT_W = 6;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTR_DIST = 3'd0,
    CFG_RADIUS    = 3'd1,
    CFG_INNER     = 3'd2,
    CFG_GAIN      = 3'd3,
    CFG_GRID_WID  = 3'd4,
    CFG_GRID_HGT  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [POS_W-1:0]  attr_dist;
    logic [POS_W-1:0]  radius;
    logic [POS_W-1:0]  inner;
    logic [POS_W-1:0]  gain;
    logic [GRID_W-1:0] grid_wid;
    logic [GRID_W-1:0] grid_hgt;
  } cfg_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [COEF_W-1:0]  coef;
    logic                      active;
    logic                      last;
  } pair_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_RAD,
    S_RANGE,
    S_SQRT,
    S_DN_GO,
    S_DN_WAIT,
    S_F_SEL,
    S_FR_WAIT,
    S_FT_WAIT,
    S_FT_MUL,
    S_U_GO,
    S_U_WAIT,
    S_U_MUL,
    S_U_ADD,
    S_FINISH,
    S_GAIN,
    S_MUL_GO,
    S_MUL,
    S_SAT,
    S_SHIFT,
    S_NEXT,
    S_EMIT
  } back_state_t;

endpackage

// ----- design/pairwise_force_accumulator.sv -----
// ----------------------------------------------------------------------------
// Pairwise force accumulator
// Sums particle-life pair forces per particle and emits the scaled total.
// ----------------------------------------------------------------------------
// Pairs are taken one at a time by the back-end sequencer while a two-entry
// queue lets the input keep streaming. A pair that is marked as the particle
// itself or falls outside the radius..cutoff ring does no force work; a pair
// inside the ring runs the 32-step square root and up to four passes through
// the shared 48-step divider (normalized distance, force curve, and one per
// axis for the unit direction). A beat with tlast adds the two 32-step gain
// multiplications before the result beat is written to the output register,
// which holds one result while work continues.
module pairwise_force_accumulator #(
  parameter int COORD_INT_BITS = pfa_pkg::COORD_INT_BITS_DEF,
  parameter int SUM_WIDTH      = pfa_pkg::SUM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // self_x[15:0], self_y[31:16], other_x[47:32], other_y[63:48],
  // coefficient[73:64], zero fill[79:74]
  input  logic [pfa_pkg::IN_DATA_W-1:0]   in_tdata,
  // same_particle
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // force_x[31:0], force_y[63:32]
  output logic [pfa_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pfa_pkg::*;

  cfg_t  cfg_r;
  logic  q_full, q_push, q_pop, q_valid;
  pair_t q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attr_dist <= 16'd5120;
      cfg_r.radius    <= 16'd128;
      cfg_r.inner     <= 16'd19661;
      cfg_r.gain      <= 16'd256;
      cfg_r.grid_wid  <= 11'd1024;
      cfg_r.grid_hgt  <= 11'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ATTR_DIST: cfg_r.attr_dist <= cfg_data;
        CFG_RADIUS:    cfg_r.radius    <= cfg_data;
        CFG_INNER:     cfg_r.inner     <= cfg_data;
        CFG_GAIN:      cfg_r.gain      <= cfg_data;
        CFG_GRID_WID:  cfg_r.grid_wid  <= cfg_data[GRID_W-1:0];
        CFG_GRID_HGT:  cfg_r.grid_hgt  <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  pfa_front #(
    .COORD_INT_BITS (COORD_INT_BITS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  pfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  pfa_back #(
    .COORD_INT_BITS (COORD_INT_BITS),
    .SUM_WIDTH      (SUM_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- design/pfa_divider.sv -----
// ----------------------------------------------------------------------------
// Pairwise force accumulator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfa_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pfa_pkg::DIV_N_W-1:0]  dividend,
  input  logic [pfa_pkg::DIV_D_W-1:0]  divisor,
  output logic                         done,
  output logic [pfa_pkg::DIV_N_W-1:0]  quotient
);
  import pfa_pkg::*;

  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_D_W:0]     rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_N_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_nxt = fits ? DIV_D_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_D_W-1:0];
    quo_nxt = {quo_r[DIV_N_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/pfa_front.sv -----
// ----------------------------------------------------------------------------
// Pairwise force accumulator front end
// Unpacks a pair beat, wraps the offset on the torus and queues the result.
// ----------------------------------------------------------------------------
module pfa_front #(
  parameter int COORD_INT_BITS = pfa_pkg::COORD_INT_BITS_DEF
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pfa_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  input  pfa_pkg::cfg_t                 cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output pfa_pkg::pair_t                q_data
);
  import pfa_pkg::*;

  localparam int POS_FRAC = POS_W - COORD_INT_BITS;
  localparam int BASE_W   = (GRID_W + POS_FRAC > POS_W + 1) ? GRID_W + POS_FRAC : POS_W + 1;
  localparam int WRAP_W   = BASE_W + 2;

  // The offset is folded at most once by w toward [-w/2, w/2]; an axis of size zero leaves it alone.
  function automatic logic signed [DELTA_W-1:0] wrap_axis(
    input logic [POS_W-1:0]  self_p,
    input logic [POS_W-1:0]  other_p,
    input logic [GRID_W-1:0] units
  );
    logic signed [WRAP_W-1:0] d;
    logic signed [WRAP_W-1:0] w;
    logic signed [WRAP_W-1:0] r;
    d = WRAP_W'($signed({1'b0, other_p})) - WRAP_W'($signed({1'b0, self_p}));
    w = WRAP_W'(units);
    w = w <<< POS_FRAC;
    if ((d <<< 1) > w) begin
      r = d - w;
    end else if ((d <<< 1) < -w) begin
      r = d + w;
    end else begin
      r = d;
    end
    return r[DELTA_W-1:0];
  endfunction

  logic [POS_W-1:0] self_x, self_y, other_x, other_y;

  assign self_x  = in_tdata[15:0];
  assign self_y  = in_tdata[31:16];
  assign other_x = in_tdata[47:32];
  assign other_y = in_tdata[63:48];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_data.dx     = wrap_axis(self_x, other_x, cfg.grid_wid);
    q_data.dy     = wrap_axis(self_y, other_y, cfg.grid_hgt);
    q_data.coef   = $signed(in_tdata[73:64]);
    q_data.active = !in_tuser;
    q_data.last   = in_tlast;
  end

endmodule

// ----- design/pfa_queue.sv -----
// ----------------------------------------------------------------------------
// Pairwise force accumulator queue
// Two-entry FIFO of classified pairs between the front and back ends.
// ----------------------------------------------------------------------------
module pfa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pfa_pkg::pair_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pfa_pkg::pair_t pop_data
);
  import pfa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  pair_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = count_r == (PTR_W + 1)'(QUEUE_DEPTH);
  assign valid    = count_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- design/pfa_back.sv -----
// ----------------------------------------------------------------------------
// Pairwise force accumulator back end
// Sequencer that computes one pair's force, accumulates it and scales sums.
// ----------------------------------------------------------------------------
`include "pairwise_force_accumulator_defines.svh"

module pfa_back #(
  parameter int COORD_INT_BITS = pfa_pkg::COORD_INT_BITS_DEF,
  parameter int SUM_WIDTH      = pfa_pkg::SUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pfa_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  input  pfa_pkg::pair_t                 q_data,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pfa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pfa_pkg::*;

  localparam int POS_FRAC  = POS_W - COORD_INT_BITS;
  localparam int PROD_W    = SUM_WIDTH + GAIN_W;
  localparam int THR_BIT   = 41 + POS_FRAC;
  localparam int V_W       = THR_BIT + 2;
  localparam int OUT_SHIFT = 8 + POS_FRAC;
  localparam logic [PROD_W-1:0] THR = PROD_W'(1) << THR_BIT;
  localparam logic signed [V_W-1:0] OUT_MAX = V_W'(2147483647);
  localparam logic signed [V_W-1:0] OUT_MIN = -OUT_MAX - 1;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  back_state_t state_r, state_nxt;

  logic [STEP_CNT_W-1:0]       cnt_r;
  pair_t                       item_r;
  logic [31:0]                 sq_a_r, sq_b_r;
  logic [32:0]                 d2_r;
  logic [34:0]                 rem_r;
  logic [ROOT_W-1:0]           root_r;
  logic [31:0]                 rad_r;
  logic [POS_W-1:0]            dn_r;
  logic [16:0]                 tent_r;
  logic signed [F_W-1:0]       f_r;
  logic signed [UNIT_W-1:0]    unit_r;
  logic signed [UPROD_W-1:0]   prod_r;
  logic signed [SUM_WIDTH-1:0] sum_x_r, sum_y_r;
  logic                        axis_r;
  logic [GAIN_W-1:0]           gain_prod_r;
  logic [PROD_W-1:0]           mc_r, acc_r;
  logic [GAIN_W-1:0]           mp_r;
  logic                        neg_r;
  logic signed [V_W-1:0]       v_r;
  logic signed [FORCE_W-1:0]   res_x_r, res_y_r;
  logic                        out_valid_r;
  logic [OUT_DATA_W-1:0]       out_data_r;

  logic                        div_start, div_done;
  logic [DIV_N_W-1:0]          div_num, div_q;
  logic [DIV_D_W-1:0]          div_den;
  logic                        emit;

  logic signed [DELTA_W-1:0]   axis_d;
  logic [POS_W-1:0]            axis_mag;
  logic signed [18:0]          tnum_s;
  logic [16:0]                 tnum_abs, tden;
  logic [34:0]                 rem_sh, trial;
  logic signed [SUM_WIDTH-1:0] axis_sum;
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_new;
  logic [SUM_WIDTH-1:0]        sum_mag;
  logic signed [27:0]          ct;
  logic signed [V_W-1:0]       v_sh;
  logic signed [FORCE_W-1:0]   res_val;

  pfa_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Shared arithmetic helpers.
  always_comb begin
    axis_d   = axis_r ? item_r.dy : item_r.dx;
    axis_mag = axis_d[DELTA_W-1] ? POS_W'(-axis_d) : axis_d[POS_W-1:0];
    axis_sum = axis_r ? sum_y_r : sum_x_r;
    sum_mag  = axis_sum[SUM_WIDTH-1] ? SUM_WIDTH'(-axis_sum) : axis_sum;
    tnum_s   = $signed({2'b00, dn_r, 1'b0}) - 19'sd65536 - $signed({3'b000, cfg.inner});
    tnum_abs = tnum_s[18] ? 17'(-tnum_s) : tnum_s[16:0];
    tden     = 17'h10000 - {1'b0, cfg.inner};
    rem_sh   = {rem_r[32:0], rad_r[31:30]};
    trial    = {1'b0, root_r, 2'b01};
    ct       = 28'(item_r.coef) * 28'($signed({1'b0, tent_r}));
    // Saturating add of the floored unit-times-force term.
    sum_ext  = {axis_sum[SUM_WIDTH-1], axis_sum} + (SUM_WIDTH + 1)'($signed(prod_r[35:16]));
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_new = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_new = sum_ext[SUM_WIDTH-1:0];
    end
    v_sh = v_r >>> OUT_SHIFT;
    if (v_sh > OUT_MAX) begin
      res_val = FORCE_W'(OUT_MAX);
    end else if (v_sh < OUT_MIN) begin
      res_val = FORCE_W'(OUT_MIN);
    end else begin
      res_val = v_sh[FORCE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = q_data.active ? S_SQ : S_FINISH;
      end
      S_SQ:    state_nxt = S_RAD;
      S_RAD:   state_nxt = S_RANGE;
      S_RANGE: state_nxt = (d2_r > 33'(sq_a_r) && d2_r < 33'(sq_b_r)) ? S_SQRT : S_FINISH;
      S_SQRT: begin
        if (cnt_r == STEP_CNT_W'(ROOT_W - 1)) state_nxt = S_DN_GO;
      end
      S_DN_GO: state_nxt = S_DN_WAIT;
      S_DN_WAIT: begin
        if (div_done) state_nxt = S_F_SEL;
      end
      S_F_SEL: begin
        if (dn_r < cfg.inner) begin
          state_nxt = S_FR_WAIT;
        end else if (cfg.inner < dn_r) begin
          state_nxt = S_FT_WAIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FR_WAIT: begin
        if (div_done) state_nxt = S_U_GO;
      end
      S_FT_WAIT: begin
        if (div_done) state_nxt = S_FT_MUL;
      end
      S_FT_MUL: state_nxt = S_U_GO;
      S_U_GO:   state_nxt = S_U_WAIT;
      S_U_WAIT: begin
        if (div_done) state_nxt = S_U_MUL;
      end
      S_U_MUL: state_nxt = S_U_ADD;
      S_U_ADD: state_nxt = axis_r ? S_FINISH : S_U_GO;
      S_FINISH: state_nxt = item_r.last ? S_GAIN : S_IDLE;
      S_GAIN:   state_nxt = S_MUL_GO;
      S_MUL_GO: state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == STEP_CNT_W'(GAIN_W - 1)) state_nxt = S_SAT;
      end
      S_SAT:   state_nxt = (acc_r > THR) ? S_NEXT : S_SHIFT;
      S_SHIFT: state_nxt = S_NEXT;
      S_NEXT:  state_nxt = axis_r ? S_EMIT : S_MUL_GO;
      S_EMIT: begin
        if (emit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    emit      = 1'b0;
    case (state_r)
      S_IDLE: q_pop = q_valid;
      S_DN_GO: begin
        div_start = 1'b1;
        div_num   = DIV_N_W'(root_r);
        div_den   = DIV_D_W'(cfg.attr_dist);
      end
      S_F_SEL: begin
        if (dn_r < cfg.inner) begin
          div_start = 1'b1;
          div_num   = DIV_N_W'({dn_r, 16'h0000});
          div_den   = DIV_D_W'(cfg.inner);
        end else if (cfg.inner < dn_r) begin
          div_start = 1'b1;
          div_num   = DIV_N_W'({tnum_abs, 16'h0000});
          div_den   = DIV_D_W'(tden);
        end
      end
      S_U_GO: begin
        div_start = 1'b1;
        div_num   = {axis_mag, 32'h0000_0000};
        div_den   = root_r;
      end
      S_EMIT: emit = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready && !emit) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) item_r <= q_data;
          axis_r <= 1'b0;
        end
        S_SQ: begin
          sq_a_r <= 32'(item_r.dx * item_r.dx);
          sq_b_r <= 32'(item_r.dy * item_r.dy);
        end
        S_RAD: begin
          d2_r   <= 33'(sq_a_r) + 33'(sq_b_r);
          sq_a_r <= cfg.radius * cfg.radius;
          sq_b_r <= cfg.attr_dist * cfg.attr_dist;
        end
        S_RANGE: begin
          rem_r  <= '0;
          root_r <= '0;
          rad_r  <= d2_r[31:0];
          cnt_r  <= '0;
        end
        S_SQRT: begin
          // One root bit per cycle; the low half of the radicand is zero.
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[ROOT_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[ROOT_W-2:0], 1'b0};
          end
          rad_r <= {rad_r[29:0], 2'b00};
          cnt_r <= cnt_r + 1'b1;
        end
        S_DN_WAIT: begin
          if (div_done) dn_r <= div_q[POS_W-1:0];
        end
        S_FR_WAIT: begin
          if (div_done) f_r <= $signed({2'b00, div_q[15:0]}) - 18'sd65536;
        end
        S_FT_WAIT: begin
          if (div_done) tent_r <= 17'h10000 - div_q[16:0];
        end
        S_FT_MUL: f_r <= F_W'(ct >>> 8);
        S_U_WAIT: begin
          if (div_done) begin
            unit_r <= axis_d[DELTA_W-1] ? -$signed({1'b0, div_q[16:0]})
                                        : $signed({1'b0, div_q[16:0]});
          end
        end
        S_U_MUL: prod_r <= UPROD_W'(unit_r) * UPROD_W'(f_r);
        S_U_ADD: begin
          if (axis_r) sum_y_r <= sum_new;
          else        sum_x_r <= sum_new;
          axis_r <= !axis_r;
        end
        S_GAIN: begin
          gain_prod_r <= cfg.gain * cfg.attr_dist;
          axis_r      <= 1'b0;
        end
        S_MUL_GO: begin
          neg_r <= axis_sum[SUM_WIDTH-1];
          mc_r  <= PROD_W'(sum_mag);
          mp_r  <= gain_prod_r;
          acc_r <= '0;
          cnt_r <= '0;
        end
        S_MUL: begin
          if (mp_r[0]) acc_r <= acc_r + mc_r;
          mc_r  <= {mc_r[PROD_W-2:0], 1'b0};
          mp_r  <= {1'b0, mp_r[GAIN_W-1:1]};
          cnt_r <= cnt_r + 1'b1;
        end
        S_SAT: begin
          if (acc_r > THR) begin
            if (axis_r) res_y_r <= neg_r ? FORCE_W'(OUT_MIN) : FORCE_W'(OUT_MAX);
            else        res_x_r <= neg_r ? FORCE_W'(OUT_MIN) : FORCE_W'(OUT_MAX);
          end else begin
            v_r <= neg_r ? -$signed({1'b0, acc_r[V_W-2:0]}) : $signed({1'b0, acc_r[V_W-2:0]});
          end
        end
        S_SHIFT: begin
          if (axis_r) res_y_r <= res_val;
          else        res_x_r <= res_val;
        end
        S_NEXT: axis_r <= !axis_r;
        S_EMIT: begin
          if (emit) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {res_y_r, res_x_r};
            sum_x_r     <= '0;
            sum_y_r     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PFA_ASSERT_SAME(a_pop_needs_entry, q_pop, q_valid)
  `PFA_ASSERT_NEXT(a_emit_clears_sums, emit, out_tvalid && sum_x_r == '0 && sum_y_r == '0)
  `PFA_ASSERT_NEXT(a_unit_bounded, state_r == S_U_WAIT && div_done,
    unit_r <= 18'sd65536 && unit_r >= -18'sd65536)

endmodule

// ----- tb/sv/pfa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise force accumulator checker
// Watches the configuration, pair and result channels, keeps its own model of
// the force sum and compares every result beat with the predicted force.
// ----------------------------------------------------------------------------
module pfa_checker
  import pfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    forces_pending
);

  localparam int  FRAC     = 16 - COORD_INT_BITS_DEF;
  localparam longint SUM_HI = (64'sd1 <<< (SUM_WIDTH_DEF - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct {
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
  } force_t;

  force_t expected_forces[$];

  longint attr, radius, inner, gain, wid, hgt;
  longint sum_fx, sum_fy;

  assign forces_pending = expected_forces.size();

  function automatic longint wrap_delta(longint d, longint units);
    longint w;
    w = units <<< FRAC;
    if (2 * d > w) d = d - w;
    if (2 * d < -w) d = d + w;
    return d;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_dir(longint d, longint root_d);
    longint q;
    q = ((d < 0 ? -d : d) <<< 32) / root_d;
    return d < 0 ? -q : q;
  endfunction

  function automatic longint curve(longint dn, longint c);
    longint num, tent;
    if (dn < inner) return ((dn <<< 16) / inner) - 65536;
    if (inner < dn && dn < 65536) begin
      num = 2 * dn - 65536 - inner;
      if (num < 0) num = -num;
      tent = 65536 - ((num <<< 16) / (65536 - inner));
      return (c * tent) >>> 8;
    end
    return 0;
  endfunction

  function automatic longint sat_sum(longint s, longint t);
    if (t > 0 && s > SUM_HI - t) return SUM_HI;
    if (t < 0 && s < SUM_LO - t) return SUM_LO;
    return s + t;
  endfunction

  function automatic logic [31:0] scaled_force(longint s);
    longint g, m, v;
    g = gain * attr;
    m = s < 0 ? -s : s;
    if (g == 0 || m == 0) return 32'd0;
    if (m > (64'sd1 <<< (41 + FRAC)) / g) return s < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v = m * g;
    if (s < 0) v = -v;
    v = v >>> (8 + FRAC);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic accumulate_pair(logic [IN_DATA_W-1:0] d, logic same, logic last);
    longint dx, dy, d2, root_d, dn, f, c;
    force_t r;
    c = longint'($signed(d[73:64]));
    if (!same) begin
      dx = wrap_delta(longint'(d[47:32]) - longint'(d[15:0]), wid);
      dy = wrap_delta(longint'(d[63:48]) - longint'(d[31:16]), hgt);
      d2 = dx * dx + dy * dy;
      if (d2 > radius * radius && d2 < attr * attr) begin
        root_d = longint'(root64(64'(d2) << 32));
        dn = root_d / attr;
        f = curve(dn, c);
        sum_fx = sat_sum(sum_fx, (unit_dir(dx, root_d) * f) >>> 16);
        sum_fy = sat_sum(sum_fy, (unit_dir(dy, root_d) * f) >>> 16);
      end
    end
    if (last) begin
      r.fx = scaled_force(sum_fx);
      r.fy = scaled_force(sum_fy);
      expected_forces.push_back(r);
      sum_fx = 0;
      sum_fy = 0;
    end
  endtask

  always @(posedge clk) begin
    force_t e;
    if (!rst_n) begin
      attr <= 5120; radius <= 128; inner <= 19661; gain <= 256;
      wid <= 1024; hgt <= 1024;
      sum_fx = 0;
      sum_fy = 0;
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_ATTR_DIST: attr   <= cfg_data;
          CFG_RADIUS:    radius <= cfg_data;
          CFG_INNER:     inner  <= cfg_data;
          CFG_GAIN:      gain   <= cfg_data;
          CFG_GRID_WID:  wid    <= cfg_data[GRID_W-1:0];
          CFG_GRID_HGT:  hgt    <= cfg_data[GRID_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) accumulate_pair(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_forces.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat %h", out_tdata);
          mismatches <= mismatches + 1;
        end else begin
          e = expected_forces.pop_front();
          if (out_tdata[31:0] !== e.fx || out_tdata[63:32] !== e.fy) begin
            if (mismatches < 10)
              $display("force mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       e.fx, e.fy, $signed(out_tdata[31:0]), $signed(out_tdata[63:32]));
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/pairwise_force_accumulator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise force accumulator testbench
// Drives directed and random particle pairs through several register settings
// with random gaps on both sides in most phases; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module pairwise_force_accumulator_tb;
  import pfa_pkg::*;

  localparam int SETTLE = 400;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser, in_tlast;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int mismatches, forces_pending;
  int long_hold = 0;
  bit no_gaps = 0;
  longint cur_attr = 5120;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pairwise_force_accumulator dut (.*);

  pfa_checker checker_i (.*);

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    int n;
    out_tready <= 1'b0;
    forever begin
      if (long_hold > 0) begin
        out_tready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ATTR_DIST) cur_attr = val;
  endtask

  task automatic set_all(logic [15:0] a, logic [15:0] r, logic [15:0] p,
                         logic [15:0] g, logic [15:0] w, logic [15:0] h);
    write_reg(CFG_ATTR_DIST, a);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_INNER, p);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_GRID_WID, w);
    write_reg(CFG_GRID_HGT, h);
  endtask

  task automatic send_pair(logic [15:0] sx, logic [15:0] sy, logic [15:0] ox,
                           logic [15:0] oy, logic signed [9:0] c, bit same, bit last);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 8);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, c, oy, ox, sy, sx};
    in_tuser  <= same;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Neighbors are mostly placed near the cutoff ring so the force path is used.
  task automatic send_random_pair();
    logic [15:0] sx, sy, ox, oy;
    int span;
    span = int'(cur_attr) + int'(cur_attr) / 4 + 2;
    sx = $urandom;
    sy = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      ox = $urandom;
      oy = $urandom;
    end else begin
      ox = sx + 16'($urandom_range(0, 2 * span) - span);
      oy = sy + 16'($urandom_range(0, 2 * span) - span);
    end
    send_pair(sx, sy, ox, oy, 10'($signed($urandom_range(0, 512)) - 256),
              $urandom_range(0, 19) == 0, $urandom_range(0, 7) == 0);
  endtask

  // A closing beat marked last ends the open run, so once its result is back
  // nothing is left in flight and the registers may be rewritten.
  task automatic drain();
    send_pair(16'd0, 16'd0, 16'd0, 16'd0, 10'sd0, 1'b1, 1'b1);
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (forces_pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: inner fraction chosen so that a pure x offset of 1536 lands on it.
    write_reg(CFG_INNER, 16'd19660);
    send_pair(16'd100, 16'd100, 16'd100, 16'd100, 10'sd0, 1'b1, 1'b1);
    send_pair(16'd500, 16'd500, 16'd500, 16'd500, 10'sd256, 1'b0, 1'b0);
    send_pair(16'd0, 16'd0, 16'd128, 16'd0, 10'sd256, 1'b0, 1'b1);
    send_pair(16'd0, 16'd0, 16'd129, 16'd0, 10'sd256, 1'b0, 1'b1);
    send_pair(16'd0, 16'd0, 16'd1536, 16'd0, -10'sd256, 1'b0, 1'b1);
    send_pair(16'd0, 16'd0, 16'd5119, 16'd0, 10'sd256, 1'b0, 1'b0);
    send_pair(16'd0, 16'd0, 16'd5120, 16'd0, 10'sd256, 1'b0, 1'b1);
    send_pair(16'd0, 16'd0, 16'd64536, 16'd64536, -10'sd256, 1'b0, 1'b0);
    send_pair(16'd65535, 16'd65535, 16'd1000, 16'd3000, 10'sd256, 1'b0, 1'b0);
    send_pair(16'd65535, 16'd0, 16'd62000, 16'd2000, 10'sd0, 1'b0, 1'b0);
    send_pair(16'd3000, 16'd3000, 16'd6000, 16'd3000, 10'sd100, 1'b0, 1'b0);
    send_pair(16'd3000, 16'd3000, 16'd3100, 16'd3100, -10'sd77, 1'b1, 1'b1);
    send_pair(16'd0, 16'd0, 16'd0, 16'd0, 10'sd0, 1'b1, 1'b1);
    drain();

    // Saturating gain with defaults elsewhere; includes the long result stall.
    set_all(16'd5120, 16'd128, 16'd19661, 16'd65535, 16'd1024, 16'd1024);
    long_hold = 3000;
    repeat (180) send_random_pair();
    drain();

    set_all(16'd65535, 16'd0, 16'd1, 16'd65535, 16'd1, 16'd1024);
    repeat (150) send_random_pair();
    drain();

    set_all(16'd1, 16'd65535, 16'd65535, 16'd0, 16'd1024, 16'd1);
    repeat (60) send_random_pair();
    drain();

    no_gaps = 1;
    set_all(16'd3000, 16'd0, 16'd65535, 16'd1, 16'd17, 16'd33);
    repeat (150) send_random_pair();
    drain();
    no_gaps = 0;

    for (int ph = 0; ph < 3; ph++) begin
      set_all(16'($urandom_range(64, 8000)), 16'($urandom_range(0, 200)),
              16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)));
      repeat (160) send_random_pair();
      drain();
    end

    if (mismatches == 0 && forces_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
